// ===== design/powq_pkg.sv =====
// shared types, defaults and state encoding for the priority wait queue insert unit
package powq_pkg;

  localparam int DEF_NUM_TASKS       = 32;
  localparam int DEF_NUM_QUEUES      = 8;
  localparam int DEF_PRIORITY_LEVELS = 16;

  localparam int FIELD_W = 6;

  typedef struct packed {
    logic [2:0]         queue_id;
    logic [FIELD_W-1:0] task_id;
    logic [4:0]         task_priority;
  } powq_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] new_head;
    logic [FIELD_W-1:0] next_task;
    logic [FIELD_W-1:0] prev_task;
  } powq_out_t;

  // write enables of the per-task tables
  typedef struct packed {
    logic next_we;
    logic prev_we;
    logic prio_we;
  } powq_wen_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_HCHK,
    ST_WALK,
    ST_LINK,
    ST_WR1,
    ST_WR2
  } powq_state_t;

endpackage

// ===== design/powq_head_table.sv =====
// per-queue head memory with reset-cleared valid bits
module powq_head_table #(
  parameter int NUM_TASKS  = powq_pkg::DEF_NUM_TASKS,
  parameter int NUM_QUEUES = powq_pkg::DEF_NUM_QUEUES,
  localparam int IW = $clog2(NUM_TASKS + 1),
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [QW-1:0] rd_addr,
  output logic [IW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [QW-1:0] wr_addr,
  input  logic [IW-1:0] wr_data
);
  import powq_pkg::*;

  logic [IW-1:0]         mem [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] vld;
  logic [IW-1:0]         rd_q;
  logic                  rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      rd_vld <= vld[rd_addr];
    end
  end

  // an unwritten head reads as an empty queue
  assign rd_data = rd_vld ? rd_q : '0;

endmodule

// ===== design/powq_link_store.sv =====
// per-task next link, previous link and priority memories
module powq_link_store #(
  parameter int NUM_TASKS       = powq_pkg::DEF_NUM_TASKS,
  parameter int PRIORITY_LEVELS = powq_pkg::DEF_PRIORITY_LEVELS,
  localparam int IW = $clog2(NUM_TASKS + 1),
  localparam int PW = $clog2(PRIORITY_LEVELS + 1)
) (
  input  logic                clk,
  input  logic [IW-1:0]       rd_addr,
  output logic [IW-1:0]       next_rd,
  output logic [IW-1:0]       prev_rd,
  output logic [PW-1:0]       prio_rd,
  input  powq_pkg::powq_wen_t wen,
  input  logic [IW-1:0]       next_wa,
  input  logic [IW-1:0]       next_wd,
  input  logic [IW-1:0]       prev_wa,
  input  logic [IW-1:0]       prev_wd,
  input  logic [IW-1:0]       prio_wa,
  input  logic [PW-1:0]       prio_wd
);
  import powq_pkg::*;

  logic [IW-1:0] next_mem [NUM_TASKS + 1];
  logic [IW-1:0] prev_mem [NUM_TASKS + 1];
  logic [PW-1:0] prio_mem [NUM_TASKS + 1];

  always_ff @(posedge clk) begin
    if (wen.next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    next_rd <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wen.prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    prev_rd <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wen.prio_we) begin
      prio_mem[prio_wa] <= prio_wd;
    end
    prio_rd <= prio_mem[rd_addr];
  end

endmodule

// ===== design/powq_ctrl.sv =====
// insert sequencer: head lookup, ring walk and link write-back
module powq_ctrl #(
  parameter int NUM_TASKS       = powq_pkg::DEF_NUM_TASKS,
  parameter int NUM_QUEUES      = powq_pkg::DEF_NUM_QUEUES,
  parameter int PRIORITY_LEVELS = powq_pkg::DEF_PRIORITY_LEVELS,
  localparam int IW = $clog2(NUM_TASKS + 1),
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
  localparam int PW = $clog2(PRIORITY_LEVELS + 1),
  localparam int SW = $clog2(NUM_TASKS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  powq_pkg::powq_in_t  cmd,
  output logic                busy,
  output logic                done,
  output powq_pkg::powq_out_t result,
  output logic [QW-1:0]       head_ra,
  input  logic [IW-1:0]       head_rd,
  output logic                head_we,
  output logic [QW-1:0]       head_wa,
  output logic [IW-1:0]       head_wd,
  output logic [IW-1:0]       link_ra,
  input  logic [IW-1:0]       next_rd,
  input  logic [IW-1:0]       prev_rd,
  input  logic [PW-1:0]       prio_rd,
  output powq_pkg::powq_wen_t link_we,
  output logic [IW-1:0]       next_wa,
  output logic [IW-1:0]       next_wd,
  output logic [IW-1:0]       prev_wa,
  output logic [IW-1:0]       prev_wd,
  output logic [IW-1:0]       prio_wa,
  output logic [PW-1:0]       prio_wd
);
  import powq_pkg::*;

  powq_state_t state, state_next;

  logic [QW-1:0] q_r;
  logic [IW-1:0] task_r;
  logic [PW-1:0] pri_r;
  logic          valid_r;
  logic          qvalid_r;
  logic [IW-1:0] head_r;
  logic [IW-1:0] ptr;
  logic [SW-1:0] steps;
  logic          newhead_r;
  logic [IW-1:0] before_r;
  logic [IW-1:0] prevt_r;

  logic          done_next;
  powq_out_t     result_next;

  logic          in_qvalid;
  logic          in_tvalid;
  logic [PW-1:0] in_pri;
  logic          head_empty;
  logic          walk_cont;
  logic [IW-1:0] prev_wr;

  // ids past the table read as the none entry
  function automatic logic [IW-1:0] slot(input logic [IW-1:0] v);
    return (int'(v) <= NUM_TASKS) ? v : '0;
  endfunction

  always_comb begin
    in_qvalid = int'(cmd.queue_id) < NUM_QUEUES;
    in_tvalid = (cmd.task_id != '0) && (int'(cmd.task_id) <= NUM_TASKS);
    if (cmd.task_priority == '0) begin
      in_pri = PW'(1);
    end else if (int'(cmd.task_priority) > PRIORITY_LEVELS) begin
      in_pri = PW'(PRIORITY_LEVELS);
    end else begin
      in_pri = PW'(cmd.task_priority);
    end
  end

  assign head_empty = (head_rd == '0);
  assign walk_cont  = (pri_r >= prio_rd) && (ptr != head_r) && (int'(steps) < NUM_TASKS);
  // a reinsert right before itself leaves the task as its own predecessor
  assign prev_wr    = (ptr == task_r) ? task_r : prev_rd;
  assign busy       = (state != ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (!valid_r || head_empty) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_HCHK;
        end
      end
      ST_HCHK: begin
        if (pri_r < prio_rd) begin
          state_next = ST_LINK;
        end else begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!walk_cont) begin
          state_next = ST_LINK;
        end
      end
      ST_LINK: state_next = ST_WR1;
      ST_WR1:  state_next = ST_WR2;
      ST_WR2:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory controls and result
  always_comb begin
    head_ra = QW'(cmd.queue_id);
    head_we = 1'b0;
    head_wa = q_r;
    head_wd = task_r;
    link_ra = ptr;
    link_we = '0;
    next_wa = task_r;
    next_wd = task_r;
    prev_wa = task_r;
    prev_wd = task_r;
    prio_wa = IW'(cmd.task_id);
    prio_wd = in_pri;
    done_next = 1'b0;
    result_next = '0;
    case (state)
      ST_IDLE: begin
        link_we.prio_we = start && in_qvalid && in_tvalid;
      end
      ST_HEAD: begin
        link_ra = slot(head_rd);
        if (!valid_r) begin
          done_next = 1'b1;
          result_next.new_head = qvalid_r ? FIELD_W'(head_rd) : '0;
        end else if (head_empty) begin
          // empty queue becomes a one-element ring
          head_we = 1'b1;
          link_we.next_we = 1'b1;
          link_we.prev_we = 1'b1;
          done_next = 1'b1;
          result_next.new_head  = FIELD_W'(task_r);
          result_next.next_task = FIELD_W'(task_r);
          result_next.prev_task = FIELD_W'(task_r);
        end
      end
      ST_HCHK, ST_WALK: begin
        link_ra = slot(next_rd);
      end
      ST_WR1: begin
        link_we.next_we = 1'b1;
        link_we.prev_we = 1'b1;
        next_wd = ptr;
        prev_wd = prev_wr;
      end
      ST_WR2: begin
        head_we = newhead_r;
        link_we.next_we = 1'b1;
        link_we.prev_we = 1'b1;
        next_wa = before_r;
        prev_wa = ptr;
        done_next = 1'b1;
        result_next.new_head  = FIELD_W'(newhead_r ? task_r : head_r);
        result_next.next_task = FIELD_W'((before_r == task_r) ? task_r : ptr);
        result_next.prev_task = FIELD_W'(prevt_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (done_next) begin
      result <= result_next;
    end
    case (state)
      ST_IDLE: begin
        if (start) begin
          q_r      <= QW'(cmd.queue_id);
          task_r   <= IW'(cmd.task_id);
          pri_r    <= in_pri;
          valid_r  <= in_qvalid && in_tvalid;
          qvalid_r <= in_qvalid;
        end
      end
      ST_HEAD: begin
        head_r <= head_rd;
      end
      ST_HCHK: begin
        newhead_r <= (pri_r < prio_rd);
        ptr       <= (pri_r < prio_rd) ? head_r : slot(next_rd);
        steps     <= SW'(1);
      end
      ST_WALK: begin
        if (walk_cont) begin
          ptr   <= slot(next_rd);
          steps <= SW'(steps + 1'b1);
        end
      end
      ST_WR1: begin
        before_r <= slot(prev_wr);
        prevt_r  <= prev_wr;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/priority_ordered_wait_queue_insert_unit.sv =====
// start to done passes ST_HEAD only for an empty queue or an invalid task or queue,
// otherwise ST_HEAD, ST_HCHK, ST_WALK unless the task goes before the head, ST_LINK, ST_WR1, ST_WR2
// a new start is taken only in ST_IDLE, one transaction at a time, and the walk reads
// one link per cycle from the link memory; busy stays high until done is set
// reset empties all queues through per-queue valid bits; link and priority tables are
// not cleared and are only read once written; results cannot be stalled by the receiver
module priority_ordered_wait_queue_insert_unit #(
  parameter int NUM_TASKS       = powq_pkg::DEF_NUM_TASKS,
  parameter int NUM_QUEUES      = powq_pkg::DEF_NUM_QUEUES,
  parameter int PRIORITY_LEVELS = powq_pkg::DEF_PRIORITY_LEVELS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  powq_pkg::powq_in_t  cmd,
  output logic                busy,
  output logic                done,
  output powq_pkg::powq_out_t result
);
  import powq_pkg::*;

  localparam int IW = $clog2(NUM_TASKS + 1);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW = $clog2(PRIORITY_LEVELS + 1);

  logic [QW-1:0] head_ra;
  logic [IW-1:0] head_rd;
  logic          head_we;
  logic [QW-1:0] head_wa;
  logic [IW-1:0] head_wd;
  logic [IW-1:0] link_ra;
  logic [IW-1:0] next_rd;
  logic [IW-1:0] prev_rd;
  logic [PW-1:0] prio_rd;
  powq_wen_t     link_we;
  logic [IW-1:0] next_wa;
  logic [IW-1:0] next_wd;
  logic [IW-1:0] prev_wa;
  logic [IW-1:0] prev_wd;
  logic [IW-1:0] prio_wa;
  logic [PW-1:0] prio_wd;

  powq_ctrl #(
    .NUM_TASKS       (NUM_TASKS),
    .NUM_QUEUES      (NUM_QUEUES),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done),
    .result  (result),
    .head_ra (head_ra),
    .head_rd (head_rd),
    .head_we (head_we),
    .head_wa (head_wa),
    .head_wd (head_wd),
    .link_ra (link_ra),
    .next_rd (next_rd),
    .prev_rd (prev_rd),
    .prio_rd (prio_rd),
    .link_we (link_we),
    .next_wa (next_wa),
    .next_wd (next_wd),
    .prev_wa (prev_wa),
    .prev_wd (prev_wd),
    .prio_wa (prio_wa),
    .prio_wd (prio_wd)
  );

  powq_head_table #(
    .NUM_TASKS  (NUM_TASKS),
    .NUM_QUEUES (NUM_QUEUES)
  ) u_head (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (head_ra),
    .rd_data (head_rd),
    .wr_en   (head_we),
    .wr_addr (head_wa),
    .wr_data (head_wd)
  );

  powq_link_store #(
    .NUM_TASKS       (NUM_TASKS),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_links (
    .clk     (clk),
    .rd_addr (link_ra),
    .next_rd (next_rd),
    .prev_rd (prev_rd),
    .prio_rd (prio_rd),
    .wen     (link_we),
    .next_wa (next_wa),
    .next_wd (next_wd),
    .prev_wa (prev_wa),
    .prev_wd (prev_wd),
    .prio_wa (prio_wa),
    .prio_wd (prio_wd)
  );

endmodule
